// ===== hw/rtl/opp_pkg.sv =====
package opp_pkg;

    localparam int MAX_FRAMES = 1024;
    localparam int IDX_W      = $clog2(MAX_FRAMES);
    localparam int CNT_W      = IDX_W + 1;
    localparam int SAMPLE_W   = 24;
    localparam int SUM_W      = SAMPLE_W + CNT_W - 1;
    localparam int THR_W      = SAMPLE_W + 1;
    localparam int WAIT_W     = 10;
    localparam int MSPAN_W    = 4;
    localparam int ASPAN_W    = 6;
    localparam int WCNT_W     = ASPAN_W + 1;
    localparam int ACC_W      = SAMPLE_W + ASPAN_W;
    localparam int PADDR_W    = 5;
    localparam int PDATA_W    = 32;

    localparam logic [2:0] REG_FIXED_THR = 3'd0;
    localparam logic [2:0] REG_DELTA     = 3'd1;
    localparam logic [2:0] REG_WAIT      = 3'd2;
    localparam logic [2:0] REG_LMAX      = 3'd3;
    localparam logic [2:0] REG_RMAX      = 3'd4;
    localparam logic [2:0] REG_LAVG      = 3'd5;
    localparam logic [2:0] REG_RAVG      = 3'd6;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] fixed_thr;
        logic signed [SAMPLE_W-1:0] delta;
        logic [WAIT_W-1:0]          wait_frames;
        logic [MSPAN_W-1:0]         lmax;
        logic [MSPAN_W-1:0]         rmax;
        logic [ASPAN_W-1:0]         lavg;
        logic [ASPAN_W-1:0]         ravg;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic thr_start;
        logic thr_take;
        logic setup;
        logic cur_rd;
        logic cur_take;
        logic walk;
        logic pre_start;
        logic pre_take;
        logic post_start;
        logic post_take;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic none_left;
        logic walk_last;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

// ===== hw/rtl/opp_regs.sv =====
module opp_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [opp_pkg::PADDR_W-1:0] paddr,
    input  logic [opp_pkg::PDATA_W-1:0] pwdata,
    output logic [opp_pkg::PDATA_W-1:0] prdata,
    output opp_pkg::t_cfg               o_cfg
);
    import opp_pkg::*;

    t_cfg       r_cfg;
    logic [2:0] idx;

    assign idx = paddr[4:2];
    assign o_cfg = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fixed_thr   <= '0;
            r_cfg.delta       <= '0;
            r_cfg.wait_frames <= '0;
            r_cfg.lmax        <= MSPAN_W'(1);
            r_cfg.rmax        <= MSPAN_W'(1);
            r_cfg.lavg        <= ASPAN_W'(1);
            r_cfg.ravg        <= ASPAN_W'(1);
        end else if (psel && penable && pwrite) begin
            unique case (idx)
                REG_FIXED_THR: r_cfg.fixed_thr   <= pwdata[SAMPLE_W-1:0];
                REG_DELTA:     r_cfg.delta       <= pwdata[SAMPLE_W-1:0];
                REG_WAIT:      r_cfg.wait_frames <= pwdata[WAIT_W-1:0];
                REG_LMAX:      r_cfg.lmax        <= pwdata[MSPAN_W-1:0];
                REG_RMAX:      r_cfg.rmax        <= pwdata[MSPAN_W-1:0];
                REG_LAVG:      r_cfg.lavg        <= pwdata[ASPAN_W-1:0];
                REG_RAVG:      r_cfg.ravg        <= pwdata[ASPAN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_FIXED_THR: prdata = PDATA_W'(unsigned'(r_cfg.fixed_thr));
            REG_DELTA:     prdata = PDATA_W'(unsigned'(r_cfg.delta));
            REG_WAIT:      prdata = PDATA_W'(r_cfg.wait_frames);
            REG_LMAX:      prdata = PDATA_W'(r_cfg.lmax);
            REG_RMAX:      prdata = PDATA_W'(r_cfg.rmax);
            REG_LAVG:      prdata = PDATA_W'(r_cfg.lavg);
            REG_RAVG:      prdata = PDATA_W'(r_cfg.ravg);
            default:       prdata = '0;
        endcase
    end

endmodule

// ===== hw/rtl/opp_div.sv =====
module opp_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic signed [opp_pkg::SUM_W-1:0] i_dividend,
    input  logic [opp_pkg::CNT_W-1:0]        i_divisor,
    output logic                             o_done,
    output logic signed [opp_pkg::SUM_W-1:0] o_quot
);
    import opp_pkg::*;

    localparam int STEP_W = $clog2(SUM_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [SUM_W-1:0]  r_mag;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_div;
    logic              r_neg;
    logic [CNT_W:0]    trial;
    logic              qbit;
    logic [CNT_W:0]    diff;

    // one quotient bit per cycle, restoring
    assign trial = {r_rem, r_mag[SUM_W-1]};
    assign diff  = trial - {1'b0, r_div};
    assign qbit  = (trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + STEP_W'(1);
                if (r_step == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mag <= i_dividend[SUM_W-1] ? SUM_W'(-i_dividend) : SUM_W'(i_dividend);
            r_neg <= i_dividend[SUM_W-1];
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= qbit ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
            r_mag <= {r_mag[SUM_W-2:0], qbit};
        end
    end

    assign o_done = r_done;
    always_comb begin
        if (r_div == '0)
            o_quot = '0;
        else if (r_neg)
            o_quot = -signed'(r_mag);
        else
            o_quot = signed'(r_mag);
    end

endmodule

// ===== hw/rtl/opp_dp.sv =====
module opp_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  opp_pkg::t_cmd                       i_cmd,
    output opp_pkg::t_sts                       o_sts,
    input  opp_pkg::t_cfg                       i_cfg,
    input  logic signed [opp_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [opp_pkg::IDX_W-1:0]           o_frame_index,
    output logic signed [opp_pkg::SAMPLE_W-1:0] o_strength,
    output logic                                o_is_onset,
    output logic                                o_scan_done
);
    import opp_pkg::*;

    logic signed [SAMPLE_W-1:0] mem [MAX_FRAMES];
    logic signed [SAMPLE_W-1:0] r_rdata;
    logic [IDX_W-1:0]           rd_addr;

    logic [CNT_W-1:0]           r_fc;
    logic signed [SUM_W-1:0]    r_sum;
    logic signed [THR_W-1:0]    r_thr;
    logic [CNT_W-1:0]           r_scan;
    logic [CNT_W-1:0]           r_prev;
    logic                       r_seen;

    logic [CNT_W-1:0]           r_i;
    logic                       r_none;
    logic [CNT_W-1:0]           r_hi_pre;
    logic [CNT_W-1:0]           r_rlim;
    logic [IDX_W-1:0]           r_lo_pre;
    logic [IDX_W-1:0]           r_end;
    logic [WCNT_W-1:0]          r_pre_cnt;
    logic [WCNT_W-1:0]          r_post_cnt;
    logic [IDX_W-1:0]           r_addr;
    logic                       r_pv;
    logic [IDX_W-1:0]           r_pj;
    logic signed [SAMPLE_W-1:0] r_cur;
    logic signed [ACC_W-1:0]    r_acc_pre;
    logic signed [ACC_W-1:0]    r_acc_post;
    logic                       r_fail_l;
    logic                       r_fail_r;
    logic signed [THR_W-1:0]    r_pre_mean;
    logic signed [THR_W-1:0]    r_post_mean;
    logic                       r_out_valid;
    logic [IDX_W-1:0]           r_o_idx;
    logic signed [SAMPLE_W-1:0] r_o_str;
    logic                       r_o_onset;
    logic                       r_o_done;

    // setup arithmetic
    logic [CNT_W-1:0] lmax_x, rmax_x, lavg_x, ravg_x;
    logic [CNT_W-1:0] ic, hi_pre, lo_pre, rlim, post_lo, post_top, post_hi;
    logic             none_left;

    // divider
    logic                    div_start;
    logic signed [SUM_W-1:0] div_num;
    logic [CNT_W-1:0]        div_den;
    logic                    div_done;
    logic signed [SUM_W-1:0] div_q;

    // decision
    logic [CNT_W-1:0]          j_x;
    logic signed [THR_W:0]     mean_sum;
    logic signed [THR_W-1:0]   mid_mean;
    logic signed [THR_W+1:0]   local_lim;
    logic                      wait_fail;
    logic                      ok;
    logic                      done_flag;
    logic [CNT_W-1:0]          i_next;

    assign lmax_x = CNT_W'(i_cfg.lmax);
    assign rmax_x = CNT_W'(i_cfg.rmax);
    assign lavg_x = CNT_W'(i_cfg.lavg);
    assign ravg_x = CNT_W'(i_cfg.ravg);

    assign ic        = (r_scan > lmax_x) ? r_scan : lmax_x;
    assign none_left = (r_fc <= rmax_x) || (ic >= r_fc - rmax_x);
    assign hi_pre    = ic - lmax_x;
    assign lo_pre    = (hi_pre > lavg_x) ? hi_pre - lavg_x : '0;
    assign rlim      = ic + rmax_x;
    assign post_lo   = rlim + CNT_W'(1);
    assign post_top  = post_lo + ravg_x;
    assign post_hi   = (post_top < r_fc) ? post_top : r_fc;

    // memory: one write port for loads, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && !r_fc[IDX_W])
            mem[r_fc[IDX_W-1:0]] <= i_sample;
        r_rdata <= mem[rd_addr];
    end

    assign rd_addr = i_cmd.cur_rd ? r_i[IDX_W-1:0] : r_addr;

    assign div_start = i_cmd.thr_start || i_cmd.pre_start || i_cmd.post_start;
    always_comb begin
        priority if (i_cmd.thr_start) begin
            div_num = r_sum;
            div_den = r_fc;
        end else if (i_cmd.pre_start) begin
            div_num = SUM_W'(r_acc_pre);
            div_den = CNT_W'(r_pre_cnt);
        end else begin
            div_num = SUM_W'(r_acc_post);
            div_den = CNT_W'(r_post_cnt);
        end
    end

    opp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_num),
        .i_divisor  (div_den),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    // candidate decision
    assign mean_sum  = (THR_W+1)'(r_pre_mean) + (THR_W+1)'(r_post_mean);
    assign mid_mean  = THR_W'((mean_sum + (THR_W+1)'(mean_sum[THR_W])) >>> 1);
    assign local_lim = (THR_W+2)'(mid_mean) + (THR_W+2)'(i_cfg.delta);
    assign wait_fail = r_seen && ((r_i - r_prev) <= CNT_W'(i_cfg.wait_frames));
    assign ok = !wait_fail && ((THR_W)'(r_cur) > r_thr) && !r_fail_l && !r_fail_r
              && ((THR_W+2)'(r_cur) > local_lim);
    assign i_next    = r_i + CNT_W'(1);
    assign done_flag = (i_next >= r_fc - rmax_x);
    assign j_x       = CNT_W'(r_pj);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fc        <= '0;
            r_sum       <= '0;
            r_thr       <= '0;
            r_scan      <= '0;
            r_prev      <= '0;
            r_seen      <= 1'b0;
            r_pv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pv <= i_cmd.walk;
            if (i_cmd.load && !r_fc[IDX_W]) begin
                r_fc  <= r_fc + CNT_W'(1);
                r_sum <= r_sum + SUM_W'(i_sample);
            end
            if (i_cmd.thr_take) begin
                if (i_cfg.fixed_thr > 0)
                    r_thr <= THR_W'(i_cfg.fixed_thr);
                else
                    r_thr <= THR_W'(div_q) + THR_W'(i_cfg.delta);
                r_scan <= '0;
                r_prev <= '0;
                r_seen <= 1'b0;
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
                if (!r_none) begin
                    r_scan <= i_next;
                    if (ok) begin
                        r_prev <= r_i;
                        r_seen <= 1'b1;
                    end
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_i        <= ic;
            r_none     <= none_left;
            r_hi_pre   <= hi_pre;
            r_rlim     <= rlim;
            r_lo_pre   <= lo_pre[IDX_W-1:0];
            r_end      <= IDX_W'(post_hi - CNT_W'(1));
            r_pre_cnt  <= WCNT_W'(hi_pre - lo_pre);
            r_post_cnt <= WCNT_W'(post_hi - post_lo);
        end
        if (i_cmd.cur_take) begin
            r_cur      <= r_rdata;
            r_addr     <= r_lo_pre;
            r_acc_pre  <= '0;
            r_acc_post <= '0;
            r_fail_l   <= 1'b0;
            r_fail_r   <= 1'b0;
        end else begin
            if (i_cmd.walk)
                r_addr <= r_addr + IDX_W'(1);
            // sort each sample into its window as it returns
            if (r_pv) begin
                priority if (j_x < r_hi_pre) begin
                    r_acc_pre <= r_acc_pre + ACC_W'(r_rdata);
                end else if (j_x < r_i) begin
                    if (r_rdata >= r_cur)
                        r_fail_l <= 1'b1;
                end else if (j_x == r_i) begin
                end else if (j_x <= r_rlim) begin
                    if (r_rdata > r_cur)
                        r_fail_r <= 1'b1;
                end else begin
                    r_acc_post <= r_acc_post + ACC_W'(r_rdata);
                end
            end
        end
        r_pj <= r_addr;
        if (i_cmd.pre_take)
            r_pre_mean <= THR_W'(div_q);
        if (i_cmd.post_take)
            r_post_mean <= THR_W'(div_q);
        if (i_cmd.finish) begin
            if (r_none) begin
                r_o_idx   <= '0;
                r_o_str   <= '0;
                r_o_onset <= 1'b0;
                r_o_done  <= 1'b1;
            end else begin
                r_o_idx   <= r_i[IDX_W-1:0];
                r_o_str   <= r_cur;
                r_o_onset <= ok;
                r_o_done  <= done_flag;
            end
        end
    end

    assign o_sts.none_left = none_left;
    assign o_sts.walk_last = (r_addr == r_end);
    assign o_sts.div_done  = div_done;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_frame_index = r_o_idx;
    assign o_strength    = r_o_str;
    assign o_is_onset    = r_o_onset;
    assign o_scan_done   = r_o_done;

endmodule

// ===== hw/rtl/opp_ctrl.sv =====
module opp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_mode,
    input  logic          i_last,
    output logic          o_in_ready,
    input  opp_pkg::t_sts i_sts,
    output opp_pkg::t_cmd o_cmd
);
    import opp_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE       = 13'b0000000000001,
        S_THR_START  = 13'b0000000000010,
        S_THR_WAIT   = 13'b0000000000100,
        S_SETUP      = 13'b0000000001000,
        S_CUR_RD     = 13'b0000000010000,
        S_CUR_WAIT   = 13'b0000000100000,
        S_WALK       = 13'b0000001000000,
        S_DRAIN      = 13'b0000010000000,
        S_PRE_START  = 13'b0000100000000,
        S_PRE_WAIT   = 13'b0001000000000,
        S_POST_START = 13'b0010000000000,
        S_POST_WAIT  = 13'b0100000000000,
        S_FINISH     = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;
    logic   accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_state <= S_IDLE;
        else
            r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_mode)
                        n_state = S_SETUP;
                    else begin
                        o_cmd.load = 1'b1;
                        if (i_last)
                            n_state = S_THR_START;
                    end
                end
            end
            S_THR_START: begin
                o_cmd.thr_start = 1'b1;
                n_state = S_THR_WAIT;
            end
            S_THR_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.thr_take = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state = i_sts.none_left ? S_FINISH : S_CUR_RD;
            end
            S_CUR_RD: begin
                o_cmd.cur_rd = 1'b1;
                n_state = S_CUR_WAIT;
            end
            S_CUR_WAIT: begin
                o_cmd.cur_take = 1'b1;
                n_state = S_WALK;
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_sts.walk_last)
                    n_state = S_DRAIN;
            end
            S_DRAIN: begin
                n_state = S_PRE_START;
            end
            S_PRE_START: begin
                o_cmd.pre_start = 1'b1;
                n_state = S_PRE_WAIT;
            end
            S_PRE_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.pre_take = 1'b1;
                    n_state = S_POST_START;
                end
            end
            S_POST_START: begin
                o_cmd.post_start = 1'b1;
                n_state = S_POST_WAIT;
            end
            S_POST_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.post_take = 1'b1;
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ===== hw/rtl/onset_peak_picker.sv =====
// a load item stores one sample; a load flagged last also runs the threshold division
// an examine item with a candidate left walks its window over the memory read port
// (one sample a cycle), then runs two serial divisions for the pre and post means
// one item is worked on at a time; a finished result waits in the output register
// synchronous active-low reset clears counters, sum, threshold, scan state and config;
// envelope memory is not cleared
module onset_peak_picker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // item in
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_mode,
    input  logic signed [opp_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                i_last,
    // item out
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [opp_pkg::IDX_W-1:0]           o_frame_index,
    output logic signed [opp_pkg::SAMPLE_W-1:0] o_strength,
    output logic                                o_is_onset,
    output logic                                o_scan_done,
    // register port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [opp_pkg::PADDR_W-1:0]         paddr,
    input  logic [opp_pkg::PDATA_W-1:0]         pwdata,
    output logic [opp_pkg::PDATA_W-1:0]         prdata,
    output logic                                pready
);
    import opp_pkg::*;

    t_cfg cfg;
    t_cmd cmd;
    t_sts sts;

    // register port never stalls
    assign pready = 1'b1;

    // configuration registers
    opp_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (cfg)
    );

    // sequencer: steps each item through load, threshold or examine phases
    opp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_mode),
        .i_last     (i_last),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // envelope memory, window walk, divider and output register
    opp_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_cfg         (cfg),
        .i_sample      (i_sample),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_frame_index (o_frame_index),
        .o_strength    (o_strength),
        .o_is_onset    (o_is_onset),
        .o_scan_done   (o_scan_done)
    );

endmodule

// ===== hw/rtl/opp_checker.sv =====
module opp_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_ready,
    input logic                                i_mode,
    input logic                                o_out_valid,
    input logic                                i_out_ready,
    input logic [opp_pkg::IDX_W-1:0]           o_frame_index,
    input logic signed [opp_pkg::SAMPLE_W-1:0] o_strength,
    input logic                                pready
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_frame_index) && $stable(o_strength))
        else $error("stalled result changed");

    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !i_mode && !o_out_valid |=> !o_out_valid)
        else $error("load item produced a result");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && pready)
        else $error("output not empty after reset");

endmodule

bind onset_peak_picker opp_checker u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .i_mode        (i_mode),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_frame_index (o_frame_index),
    .o_strength    (o_strength),
    .pready        (pready)
);

// ===== bench/onset_peak_picker_tb.sv =====
module onset_peak_picker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import opp_pkg::*;

    // one input item and one result item as the block sees them
    typedef struct packed {
        logic                       mode;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } env_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]           frame_index;
        logic signed [SAMPLE_W-1:0] strength;
        logic                       is_onset;
        logic                       scan_done;
    } onset_result_t;

    localparam logic MODE_LOAD    = 1'b0;
    localparam logic MODE_EXAMINE = 1'b1;
    localparam int   SETTLE_CYCLES = 400;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_in_valid;
    logic                       o_in_ready;
    logic                       i_mode;
    logic signed [SAMPLE_W-1:0] i_sample;
    logic                       i_last;
    logic                       o_out_valid;
    logic                       i_out_ready;
    logic [IDX_W-1:0]           o_frame_index;
    logic signed [SAMPLE_W-1:0] o_strength;
    logic                       o_is_onset;
    logic                       o_scan_done;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [PADDR_W-1:0]         paddr;
    logic [PDATA_W-1:0]         pwdata;
    logic [PDATA_W-1:0]         prdata;
    logic                       pready;

    onset_peak_picker dut (.*);

    // pending items for the driver, results still owed by the block
    env_item_t     pending_items[$];
    onset_result_t owed_results[$];
    int            errors = 0;
    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;

    // predictor state
    int          env_store[MAX_FRAMES];
    int          frame_cnt;
    longint      env_sum;
    longint      active_thr;
    int          scan_pos;
    int          prev_onset;
    bit          onset_seen;
    // predictor copy of the registers
    longint      thr_cfg;
    longint      delta_cfg;
    int          wait_cfg;
    int          lmax_cfg;
    int          rmax_cfg;
    int          lavg_cfg;
    int          ravg_cfg;

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // work out what one accepted item does to the envelope and the scan
    function automatic void pick_peak(env_item_t it);
        int            n;
        int            i;
        int            j;
        int            lo;
        int            hi;
        int            cnt;
        longint        cur;
        longint        acc;
        longint        pre_mean;
        longint        post_mean;
        longint        mid_mean;
        bit            ok;
        onset_result_t r;
        n = frame_cnt;
        if (it.mode == MODE_LOAD) begin
            // a full store drops the sample but still honours last
            if (frame_cnt < MAX_FRAMES) begin
                env_store[frame_cnt] = int'(it.sample);
                env_sum += longint'(it.sample);
                frame_cnt++;
            end
            if (it.last) begin
                if (thr_cfg > 0)
                    active_thr = thr_cfg;
                else
                    active_thr = env_sum / longint'(frame_cnt) + delta_cfg;
                scan_pos   = 0;
                prev_onset = 0;
                onset_seen = 0;
            end
            return;
        end
        i = (scan_pos > lmax_cfg) ? scan_pos : lmax_cfg;
        // no candidate left: fixed answer, scan position held
        if (n <= rmax_cfg || i >= n - rmax_cfg) begin
            r = '0;
            r.scan_done = 1'b1;
            owed_results.insert(owed_results.size(), r);
            return;
        end
        cur = env_store[i];
        ok  = 1'b1;
        if (onset_seen && i - prev_onset <= wait_cfg)
            ok = 1'b0;
        if (ok && cur <= active_thr)
            ok = 1'b0;
        // strict on the left, ties allowed on the right
        for (j = i - lmax_cfg; ok && j < i; j++)
            if (env_store[j] >= cur) ok = 1'b0;
        for (j = i + 1; ok && j <= i + rmax_cfg; j++)
            if (env_store[j] > cur) ok = 1'b0;
        if (ok) begin
            hi  = i - lmax_cfg;
            lo  = (hi > lavg_cfg) ? hi - lavg_cfg : 0;
            acc = 0;
            cnt = 0;
            for (j = lo; j < hi; j++) begin
                acc += env_store[j];
                cnt++;
            end
            pre_mean = cnt ? acc / cnt : 0;
            lo  = i + rmax_cfg + 1;
            hi  = i + rmax_cfg + ravg_cfg + 1;
            if (hi > n) hi = n;
            acc = 0;
            cnt = 0;
            for (j = lo; j < hi; j++) begin
                acc += env_store[j];
                cnt++;
            end
            post_mean = cnt ? acc / cnt : 0;
            mid_mean = (pre_mean + post_mean) / 2;
            if (cur <= mid_mean + delta_cfg)
                ok = 1'b0;
        end
        if (ok) begin
            prev_onset = i;
            onset_seen = 1'b1;
        end
        scan_pos = i + 1;
        r.frame_index = i[IDX_W-1:0];
        r.strength    = cur[SAMPLE_W-1:0];
        r.is_onset    = ok;
        r.scan_done   = (i + 1 >= n - rmax_cfg);
        owed_results.insert(owed_results.size(), r);
    endfunction

    // driver: next item goes out once the slot frees up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready)
                pick_peak({i_mode, i_sample, i_last});
            if (!i_in_valid || o_in_ready) begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    env_item_t it;
                    it = pending_items.pop_front();
                    i_mode     <= it.mode;
                    i_sample   <= it.sample;
                    i_last     <= it.last;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stalls
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // monitor: every accepted result against the oldest one owed
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (owed_results.size() == 0) begin
                $display("%0t: unexpected result frame %0d", $realtime, o_frame_index);
                errors++;
            end else begin
                onset_result_t e;
                e = owed_results.pop_front();
                if (o_frame_index !== e.frame_index) begin
                    $display("%0t: frame_index expected %0d actual %0d",
                             $realtime, e.frame_index, o_frame_index);
                    errors++;
                end
                if (o_strength !== e.strength) begin
                    $display("%0t: strength expected %0d actual %0d",
                             $realtime, e.strength, o_strength);
                    errors++;
                end
                if (o_is_onset !== e.is_onset) begin
                    $display("%0t: is_onset expected %0b actual %0b (frame %0d)",
                             $realtime, e.is_onset, o_is_onset, e.frame_index);
                    errors++;
                end
                if (o_scan_done !== e.scan_done) begin
                    $display("%0t: scan_done expected %0b actual %0b (frame %0d)",
                             $realtime, e.scan_done, o_scan_done, e.frame_index);
                    errors++;
                end
            end
        end
    end

    // register write: setup cycle then access cycle
    task automatic write_reg(logic [2:0] idx, logic [PDATA_W-1:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_FIXED_THR: thr_cfg   = longint'($signed(val[SAMPLE_W-1:0]));
            REG_DELTA:     delta_cfg = longint'($signed(val[SAMPLE_W-1:0]));
            REG_WAIT:      wait_cfg  = int'(val[WAIT_W-1:0]);
            REG_LMAX:      lmax_cfg  = int'(val[MSPAN_W-1:0]);
            REG_RMAX:      rmax_cfg  = int'(val[MSPAN_W-1:0]);
            REG_LAVG:      lavg_cfg  = int'(val[ASPAN_W-1:0]);
            REG_RAVG:      ravg_cfg  = int'(val[ASPAN_W-1:0]);
            default: ;
        endcase
    endtask

    // hold off until everything sent has been answered and the block is quiet
    task automatic drain();
        while (pending_items.size() > 0 || i_in_valid || owed_results.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic push_item(logic mode, logic signed [SAMPLE_W-1:0] s, logic lst);
        env_item_t it;
        it = {mode, s, lst};
        pending_items.insert(pending_items.size(), it);
    endtask

    // peaky envelope: low noise, spikes, plateaus, now and then anything at all
    function automatic logic signed [SAMPLE_W-1:0] next_sample(logic signed [SAMPLE_W-1:0] prev);
        int pick;
        pick = $urandom_range(99);
        if (pick < 10) return prev;
        if (pick < 25) return SAMPLE_W'($urandom_range(200000, 4000));
        if (pick < 30) return SAMPLE_W'($urandom());
        return SAMPLE_W'(int'($urandom_range(2000)) - 1000);
    endfunction

    task automatic load_envelope(int count, bit with_last);
        logic signed [SAMPLE_W-1:0] s;
        s = '0;
        for (int k = 0; k < count; k++) begin
            s = next_sample(s);
            push_item(MODE_LOAD, s, with_last && (k == count - 1));
        end
    endtask

    task automatic examine(int count);
        for (int k = 0; k < count; k++)
            push_item(MODE_EXAMINE, SAMPLE_W'($urandom()), 1'($urandom_range(1)));
    endtask

    task automatic random_config(bit extremes);
        if (extremes) begin
            write_reg(REG_FIXED_THR, $urandom_range(1) ? 32'h7FFFFF : 32'h800000);
            write_reg(REG_DELTA,     $urandom_range(1) ? 32'h7FFFFF : 32'h800000);
            write_reg(REG_WAIT,      $urandom_range(1) ? 1023 : 0);
            write_reg(REG_LMAX,      $urandom_range(1) ? 15 : 0);
            write_reg(REG_RMAX,      $urandom_range(1) ? 15 : 0);
            write_reg(REG_LAVG,      $urandom_range(1) ? 63 : 0);
            write_reg(REG_RAVG,      $urandom_range(1) ? 63 : 0);
        end else begin
            // mostly adaptive threshold, sometimes a small fixed one
            write_reg(REG_FIXED_THR, $urandom_range(2) == 0 ? $urandom_range(8000, 1)
                                                            : -$urandom_range(50000));
            write_reg(REG_DELTA,     $urandom_range(6000) - 3000);
            write_reg(REG_WAIT,      $urandom_range(3) == 0 ? $urandom_range(1023)
                                                            : $urandom_range(4));
            write_reg(REG_LMAX,      $urandom_range(15));
            write_reg(REG_RMAX,      $urandom_range(15));
            write_reg(REG_LAVG,      $urandom_range(63));
            write_reg(REG_RAVG,      $urandom_range(63));
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_mode      = MODE_LOAD;
        i_sample    = '0;
        i_last      = 1'b0;
        i_out_ready = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        frame_cnt   = 0;
        env_sum     = 0;
        active_thr  = 0;
        scan_pos    = 0;
        prev_onset  = 0;
        onset_seen  = 0;
        thr_cfg     = 0;
        delta_cfg   = 0;
        wait_cfg    = 0;
        lmax_cfg    = 1;
        rmax_cfg    = 1;
        lavg_cfg    = 1;
        ravg_cfg    = 1;
        foreach (env_store[k]) env_store[k] = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 34;
        recv_idle_pct = 53;

        // directed: examine on an empty store, then extremes under reset config
        examine(2);
        push_item(MODE_LOAD, 24'sd0, 1'b0);
        push_item(MODE_LOAD, 24'sh7FFFFF, 1'b0);
        push_item(MODE_LOAD, 24'sh800000, 1'b0);
        push_item(MODE_LOAD, 24'sd5000, 1'b0);
        push_item(MODE_LOAD, 24'sd5000, 1'b0);
        push_item(MODE_LOAD, 24'sd4999, 1'b0);
        push_item(MODE_LOAD, 24'sd9000, 1'b0);
        push_item(MODE_LOAD, -24'sd1, 1'b1);
        examine(8);
        // examine ahead of the scan end, then more loads without last extend it
        push_item(MODE_LOAD, 24'sd12000, 1'b0);
        push_item(MODE_LOAD, 24'sd0, 1'b0);
        examine(3);
        drain();

        // fixed threshold path with the widest left and averaging windows and no right window
        write_reg(REG_FIXED_THR, 32'd3000);
        write_reg(REG_LMAX, 15);
        write_reg(REG_RMAX, 0);
        write_reg(REG_LAVG, 63);
        write_reg(REG_RAVG, 63);
        load_envelope(20, 1'b1);
        examine(12);
        drain();

        for (int ph = 0; ph < 24; ph++) begin
            if (ph == 8) begin
                send_idle_pct = 53;
                recv_idle_pct = 34;
            end else if (ph == 16) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            random_config(ph % 5 == 4);
            // some phases only carry on the current scan under new settings
            if (ph % 6 != 5)
                load_envelope($urandom_range(14, 2), $urandom_range(4) != 0);
            examine($urandom_range(20, 4));
            drain();
        end

        // adaptive threshold with a wide right window on a fresh scan
        write_reg(REG_FIXED_THR, 32'h800000);
        write_reg(REG_DELTA, 32'd500);
        write_reg(REG_WAIT, 3);
        write_reg(REG_LMAX, 2);
        write_reg(REG_RMAX, 15);
        write_reg(REG_LAVG, 4);
        write_reg(REG_RAVG, 63);
        load_envelope(24, 1'b1);
        examine(20);
        drain();

        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #4000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
